### rtl/cmykf_pkg.sv
// Shared types and constants of the CMYK channel mask filter.
// No dependencies; every other file of the block uses it by scoped names.
package cmykf_pkg;

	localparam int CH_W      = 8;
	localparam int NUM_CH    = 3;
	localparam int DIV_STEPS = CH_W;
	localparam int NUM_W     = 2 * CH_W;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [NUM_W-1:0] num_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEEP_CYAN    = 8'd0,
		CFG_KEEP_MAGENTA = 8'd1,
		CFG_KEEP_YELLOW  = 8'd2,
		CFG_KEEP_BLACK   = 8'd3
	} cfg_idx_t;

endpackage

### rtl/cmykf_in_if.sv
// Input pixel channel: valid, ready and one RGB pixel.
// Depends on cmykf_pkg for the channel width.
interface cmykf_in_if;
	logic                valid;
	logic                ready;
	cmykf_pkg::chan_t    red_in;
	cmykf_pkg::chan_t    green_in;
	cmykf_pkg::chan_t    blue_in;

	modport source (output valid, red_in, green_in, blue_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

### rtl/cmykf_out_if.sv
// Output pixel channel: valid, ready and one filtered RGB pixel.
// Depends on cmykf_pkg for the channel width.
interface cmykf_out_if;
	logic                valid;
	logic                ready;
	cmykf_pkg::chan_t    red_out;
	cmykf_pkg::chan_t    green_out;
	cmykf_pkg::chan_t    blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

### rtl/cmykf_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
// Depends on cmykf_pkg for the index and data widths.
interface cmykf_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [cmykf_pkg::CFG_IDX_W-1:0]       index;
	logic [cmykf_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/cmyk_channel_mask_filter_core.sv
// CMYK channel mask filter, top level: RGB to CMYK, component masking, back to RGB.
// Depends on cmykf_pkg and the interfaces cmykf_in_if, cmykf_out_if, cmykf_cfg_if.
//
// Usage:
// Pixels arrive on pix_in and leave on pix_out, both valid/ready channels; a
// request is taken at a rising edge with valid and ready high. Each input pixel
// gives exactly one output pixel, in order.
// The cfg channel writes the four keep flags (cyan, magenta, yellow, black at
// indexes 0 to 3); only bit 0 of the data is stored, other indexes are ignored.
// It is always ready and should be written only while the pipeline is empty.
// The datapath is a 13-stage pipeline: one max/difference stage, one scaling
// stage, eight stages of a restoring divider (one quotient bit each, three
// lanes side by side), a multiply stage, a divide-by-255 estimate and a final
// correction stage that is also the output register. One pixel is taken every
// cycle unless a stalled receiver has backed the pipeline up.
// Each stage has its own valid bit and moves when the next one is free, so a
// stalled receiver holds pix_out while gaps further back still fill up.
// Reset clears all valid bits and sets every keep flag to 1.
module cmyk_channel_mask_filter_core (
	input  logic         clk,
	input  logic         arst_n,
	cmykf_in_if.sink     pix_in,
	cmykf_out_if.source  pix_out,
	cmykf_cfg_if.sink    cfg
);

	localparam int NC = cmykf_pkg::NUM_CH;
	localparam int DS = cmykf_pkg::DIV_STEPS;
	localparam int CW = cmykf_pkg::CH_W;
	localparam int NW = cmykf_pkg::NUM_W;

	logic [NC-1:0] keep_cmy_q;
	logic          keep_k_q;

	// Pipeline valids and stage enables.
	logic          v_s1, v_s2, v_s11, v_s12, v_s13;
	logic [DS-1:0] v_dv;
	logic          en_s1, en_s2, en_s11, en_s12, en_s13;
	logic [DS-1:0] en_dv;

	// Stage payloads. Entry j of the dv arrays is divider stage 3+j.
	cmykf_pkg::chan_t                 d_s1, d_s2;
	logic [NC-1:0][CW-1:0]            diff_s1;
	logic [NC-1:0][NW-1:0]            num_s2;
	logic [DS-1:0][CW-1:0]            dv_d_s3;
	logic [DS-1:0][NC-1:0][NW-1:0]    dv_rem_s3;
	logic [DS-1:0][NC-1:0][DS-1:0]    dv_quo_s3;
	logic [NC-1:0][NW-1:0]            n_s11, n_s12;
	logic [NC-1:0][CW:0]              q0_s12;
	logic [NC-1:0][CW-1:0]            rgb_s13;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_cmy_q <= '1;
			keep_k_q   <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				cmykf_pkg::CFG_KEEP_CYAN:    keep_cmy_q[0] <= cfg.data[0];
				cmykf_pkg::CFG_KEEP_MAGENTA: keep_cmy_q[1] <= cfg.data[0];
				cmykf_pkg::CFG_KEEP_YELLOW:  keep_cmy_q[2] <= cfg.data[0];
				cmykf_pkg::CFG_KEEP_BLACK:   keep_k_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its contents move on.
	always_comb begin
		en_s13 = !v_s13 || pix_out.ready;
		en_s12 = !v_s12 || en_s13;
		en_s11 = !v_s11 || en_s12;
		en_dv[DS-1] = !v_dv[DS-1] || en_s11;
		for (int j = DS - 2; j >= 0; j--) begin
			en_dv[j] = !v_dv[j] || en_dv[j+1];
		end
		en_s2 = !v_s2 || en_dv[0];
		en_s1 = !v_s1 || en_s2;
	end

	assign pix_in.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_dv  <= '0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_in.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_dv[0]) v_dv[0] <= v_s2;
			for (int j = 1; j < DS; j++) begin
				if (en_dv[j]) v_dv[j] <= v_dv[j-1];
			end
			if (en_s11) v_s11 <= v_dv[DS-1];
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
		end
	end

	// Stage 1: the largest channel is 255 - k; differences are x - k in CMYK terms.
	logic [NC-1:0][CW-1:0] px_in;
	cmykf_pkg::chan_t      mx_rg, mx;

	always_comb begin
		px_in[0] = pix_in.red_in;
		px_in[1] = pix_in.green_in;
		px_in[2] = pix_in.blue_in;
		mx_rg = (px_in[0] > px_in[1]) ? px_in[0] : px_in[1];
		mx    = (mx_rg > px_in[2]) ? mx_rg : px_in[2];
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d_s1 <= mx;
			for (int c = 0; c < NC; c++) begin
				diff_s1[c] <= mx - px_in[c];
			end
		end
	end

	// Stage 2: numerator = difference * 255.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			d_s2 <= d_s1;
			for (int c = 0; c < NC; c++) begin
				num_s2[c] <= {diff_s1[c], {CW{1'b0}}} - NW'(diff_s1[c]);
			end
		end
	end

	// Divider stages: one quotient bit per stage, most significant first.
	logic [DS-1:0][NC-1:0][NW-1:0] dv_rem_nx;
	logic [DS-1:0][NC-1:0][DS-1:0] dv_quo_nx;
	logic [DS-1:0][CW-1:0]         dv_d_nx;

	always_comb begin
		logic [NC-1:0][NW-1:0] rem_in;
		logic [NC-1:0][DS-1:0] quo_in;
		cmykf_pkg::chan_t      d_in;
		cmykf_pkg::num_t       dvs;
		for (int j = 0; j < DS; j++) begin
			if (j == 0) begin
				rem_in = num_s2;
				quo_in = '0;
				d_in   = d_s2;
			end else begin
				rem_in = dv_rem_s3[j-1];
				quo_in = dv_quo_s3[j-1];
				d_in   = dv_d_s3[j-1];
			end
			dvs = NW'(d_in) << (DS - 1 - j);
			dv_d_nx[j] = d_in;
			for (int c = 0; c < NC; c++) begin
				if (rem_in[c] >= dvs) begin
					dv_rem_nx[j][c] = rem_in[c] - dvs;
					dv_quo_nx[j][c] = quo_in[c] | (DS'(1) << (DS - 1 - j));
				end else begin
					dv_rem_nx[j][c] = rem_in[c];
					dv_quo_nx[j][c] = quo_in[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DS; j++) begin
			if (en_dv[j]) begin
				dv_d_s3[j]   <= dv_d_nx[j];
				dv_rem_s3[j] <= dv_rem_nx[j];
				dv_quo_s3[j] <= dv_quo_nx[j];
			end
		end
	end

	// Stage 11: masking and the back-conversion numerator x*(255-k) + 255*k.
	// A black pixel (largest channel zero) has zero cyan, magenta and yellow.
	cmykf_pkg::chan_t d_fin, kk, wt;
	logic [NC-1:0][CW-1:0] cmy;

	always_comb begin
		d_fin = dv_d_s3[DS-1];
		kk    = keep_k_q ? (cmykf_pkg::CH_MAX - d_fin) : '0;
		wt    = keep_k_q ? d_fin : cmykf_pkg::CH_MAX;
		for (int c = 0; c < NC; c++) begin
			cmy[c] = (keep_cmy_q[c] && d_fin != '0) ? dv_quo_s3[DS-1][c] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			for (int c = 0; c < NC; c++) begin
				n_s11[c] <= NW'(NW'(cmy[c]) * NW'(wt) + {kk, {CW{1'b0}}} - NW'(kk));
			end
		end
	end

	// Stage 12: estimate of n / 255, low by at most one.
	logic [NC-1:0][NW:0] est_sum;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			est_sum[c] = {1'b0, n_s11[c]} + (NW+1)'(n_s11[c] >> CW);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s12) begin
			n_s12 <= n_s11;
			for (int c = 0; c < NC; c++) begin
				q0_s12[c] <= est_sum[c][NW:CW];
			end
		end
	end

	// Stage 13: correct the estimate, saturate and invert.
	logic [NC-1:0][NW:0] rem_fix;
	logic [NC-1:0][CW:0] q_fix;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			rem_fix[c] = {1'b0, n_s12[c]}
				- (({q0_s12[c], {CW{1'b0}}}) - (NW+1)'(q0_s12[c]));
			q_fix[c] = q0_s12[c]
				+ (CW+1)'(rem_fix[c] >= (NW+1)'(cmykf_pkg::CH_MAX));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s13) begin
			for (int c = 0; c < NC; c++) begin
				rgb_s13[c] <= (q_fix[c] > (CW+1)'(cmykf_pkg::CH_MAX)) ? '0
					: cmykf_pkg::CH_MAX - q_fix[c][CW-1:0];
			end
		end
	end

	assign pix_out.valid     = v_s13;
	assign pix_out.red_out   = rgb_s13[0];
	assign pix_out.green_out = rgb_s13[1];
	assign pix_out.blue_out  = rgb_s13[2];

	// The input side only stalls when the output register holds a pixel nobody takes.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (pix_out.valid && !pix_out.ready))
		else $error("input stalled without output back-pressure");

	// After the last divider step each remainder lies below the divisor.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv[DS-1] && dv_d_s3[DS-1] != '0) |->
			(dv_rem_s3[DS-1][0] < NW'(dv_d_s3[DS-1])
			&& dv_rem_s3[DS-1][1] < NW'(dv_d_s3[DS-1])
			&& dv_rem_s3[DS-1][2] < NW'(dv_d_s3[DS-1])))
		else $error("divider remainder not below divisor");

	// The divide-by-255 estimate needs at most one correction.
	a_est_error: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 |-> (rem_fix[0] < (NW+1)'(2 * 255) && rem_fix[1] < (NW+1)'(2 * 255)
			&& rem_fix[2] < (NW+1)'(2 * 255)))
		else $error("divide-by-255 estimate off by more than one");

	// A pixel moving out of the estimate stage is shown on the output next cycle.
	a_last_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s12 && en_s13) |=> pix_out.valid)
		else $error("pixel lost between the last two stages");

endmodule

### tb/sv/tb_cmyk_channel_mask_filter_core.sv
// Self-checking testbench of cmyk_channel_mask_filter_core: directed pixels, then random phases
// over several keep-flag settings and idling patterns, each result checked by predictor or table.
// Depends on cmykf_pkg, the interfaces cmykf_in_if, cmykf_out_if, cmykf_cfg_if and the core.
module tb_cmyk_channel_mask_filter_core;

	localparam int unsigned FULL           = 255;
	localparam int          PIPE_DEPTH     = 13;
	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          NUM_PHASES     = 8;
	localparam int          PHASE_PIXELS   = 130;

	typedef struct packed {
		cmykf_pkg::chan_t r;
		cmykf_pkg::chan_t g;
		cmykf_pkg::chan_t b;
	} rgb_t;

	typedef struct packed {
		logic cyan;
		logic magenta;
		logic yellow;
		logic black;
	} keep_t;

	typedef enum logic [1:0] {
		ROW_PIXEL,
		ROW_WRITE
	} row_kind_t;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  idx;
		logic [7:0]  data;
		rgb_t        pix;
		logic        typed;
		rgb_t        want;
	} row_t;

	localparam int NUM_ROWS = 26;
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd255, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd0, 8'd0}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd255, 8'd0, 8'd0}, 1'b1, {8'd255, 8'd0, 8'd0}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd255, 8'd0}, 1'b1, {8'd0, 8'd255, 8'd0}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd0, 8'd255}, 1'b1, {8'd0, 8'd0, 8'd255}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd128, 8'd128, 8'd128}, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd1, 8'd254, 8'd127}, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd254, 8'd1, 8'd0}, 1'b0, 24'h0},
		'{ROW_WRITE, cmykf_pkg::CFG_KEEP_BLACK, 8'h00, 24'h0, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd128, 8'd128, 8'd128}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd200, 8'd30, 8'd90}, 1'b0, 24'h0},
		'{ROW_WRITE, cmykf_pkg::CFG_KEEP_BLACK, 8'hFF, 24'h0, 1'b0, 24'h0},
		'{ROW_WRITE, cmykf_pkg::CFG_KEEP_CYAN, 8'hFE, 24'h0, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd10, 8'd200, 8'd77}, 1'b0, 24'h0},
		'{ROW_WRITE, 8'h04, 8'hFF, 24'h0, 1'b0, 24'h0},
		'{ROW_WRITE, 8'hFF, 8'h00, 24'h0, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_WRITE, cmykf_pkg::CFG_KEEP_MAGENTA, 8'h00, 24'h0, 1'b0, 24'h0},
		'{ROW_WRITE, cmykf_pkg::CFG_KEEP_YELLOW, 8'h02, 24'h0, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd37, 8'd99, 8'd180}, 1'b1, {8'd180, 8'd180, 8'd180}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd255, 8'd255, 8'd255}, 1'b1, {8'd255, 8'd255, 8'd255}},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd0, 8'd0, 8'd0}, 1'b1, {8'd0, 8'd0, 8'd0}},
		'{ROW_WRITE, cmykf_pkg::CFG_KEEP_CYAN, 8'h01, 24'h0, 1'b0, 24'h0},
		'{ROW_PIXEL, 8'h00, 8'h00, {8'd77, 8'd160, 8'd3}, 1'b0, 24'h0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cmykf_in_if  pix_in();
	cmykf_out_if pix_out();
	cmykf_cfg_if cfg();

	keep_t       keep_state = 4'hF;
	rgb_t        expected_pixels [$];
	rgb_t        oldest_pixel;
	rgb_t        typed_pixel;
	logic        typed_pending = 1'b0;
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int          fault_count = 0;
	int          quiet_cycles = 0;
	logic [3:0]  phase_flags;

	cmyk_channel_mask_filter_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned scale_ink(int unsigned x, int unsigned k);
		if (k >= FULL) begin
			return 0;
		end
		return ((x - k) * FULL) / (FULL - k);
	endfunction

	function automatic cmykf_pkg::chan_t ink_to_channel(int unsigned x, int unsigned k);
		int unsigned v;
		v = (x * (FULL - k) + FULL * k) / FULL;
		if (v > FULL) begin
			v = FULL;
		end
		return cmykf_pkg::chan_t'(FULL - v);
	endfunction

	function automatic rgb_t filter_pixel(rgb_t px, keep_t keep);
		int unsigned c, m, y, k, ink_c, ink_m, ink_y, ink_k;
		rgb_t res;
		c = FULL - px.r;
		m = FULL - px.g;
		y = FULL - px.b;
		k = (c < m) ? c : m;
		k = (k < y) ? k : y;
		// The CMY components are scaled with the true black even when black is masked.
		ink_c = keep.cyan ? scale_ink(c, k) : 0;
		ink_m = keep.magenta ? scale_ink(m, k) : 0;
		ink_y = keep.yellow ? scale_ink(y, k) : 0;
		ink_k = keep.black ? k : 0;
		res.r = ink_to_channel(ink_c, ink_k);
		res.g = ink_to_channel(ink_m, ink_k);
		res.b = ink_to_channel(ink_y, ink_k);
		return res;
	endfunction

	function automatic rgb_t random_pixel();
		rgb_t p;
		int unsigned sel;
		sel = $urandom_range(9);
		p.r = 8'($urandom_range(255));
		p.g = 8'($urandom_range(255));
		p.b = 8'($urandom_range(255));
		if (sel < 2) begin
			p.g = p.r;
			p.b = p.r;
		end else if (sel == 2) begin
			p.b = p.g;
		end else if (sel == 3) begin
			p.r = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
			p.g = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
			p.b = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
		end
		return p;
	endfunction

	function automatic void check_chan(string name, cmykf_pkg::chan_t want,
			cmykf_pkg::chan_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endfunction

	function automatic void set_idle(idle_mode_t mode);
		unique case (mode)
			IDLE_NONE: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct = 78;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 78;
			end
			default: begin
				gap_pct = 35;
				stall_pct = 35;
			end
		endcase
	endfunction

	// All drive tasks start and end on a falling edge; valid is left high after a
	// request so that back-to-back requests never lower and raise it in one step.
	task automatic send_pixel(input rgb_t px);
		while ($urandom_range(99) < gap_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.red_in   <= px.r;
		pix_in.green_in <= px.g;
		pix_in.blue_in  <= px.b;
		do @(posedge clk); while (!pix_in.ready);
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		pix_in.valid <= 1'b0;
		do @(negedge clk); while (expected_pixels.size() != 0);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	task automatic apply_keep(input logic [3:0] flags);
		drain_pipeline();
		write_reg(cmykf_pkg::CFG_KEEP_CYAN, {7'($urandom), flags[3]});
		write_reg(cmykf_pkg::CFG_KEEP_MAGENTA, {7'($urandom), flags[2]});
		write_reg(cmykf_pkg::CFG_KEEP_YELLOW, {7'($urandom), flags[1]});
		write_reg(cmykf_pkg::CFG_KEEP_BLACK, {7'($urandom), flags[0]});
		write_reg(8'($urandom_range(255, 4)), 8'($urandom));
		cfg.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		pix_out.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (cfg.valid && cfg.ready) ||
				(pix_out.valid && pix_out.ready && expected_pixels.size() != 0)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end

		if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				cmykf_pkg::CFG_KEEP_CYAN:    keep_state.cyan = cfg.data[0];
				cmykf_pkg::CFG_KEEP_MAGENTA: keep_state.magenta = cfg.data[0];
				cmykf_pkg::CFG_KEEP_YELLOW:  keep_state.yellow = cfg.data[0];
				cmykf_pkg::CFG_KEEP_BLACK:   keep_state.black = cfg.data[0];
				default: ;
			endcase
		end

		if (pix_in.valid && pix_in.ready) begin
			if (typed_pending) begin
				expected_pixels.push_back(typed_pixel);
			end else begin
				expected_pixels.push_back(filter_pixel({pix_in.red_in, pix_in.green_in,
					pix_in.blue_in}, keep_state));
			end
		end

		if (pix_out.valid && pix_out.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("output pixel %0d/%0d/%0d with no request pending", pix_out.red_out,
					pix_out.green_out, pix_out.blue_out);
				fault_count++;
			end else begin
				oldest_pixel = expected_pixels.pop_front();
				check_chan("red_out", oldest_pixel.r, pix_out.red_out);
				check_chan("green_out", oldest_pixel.g, pix_out.green_out);
				check_chan("blue_out", oldest_pixel.b, pix_out.blue_out);
			end
		end

		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("cmyk_channel_mask_filter_core test failed");
			$finish;
		end
	end

	initial begin
		pix_in.valid    = 1'b0;
		pix_in.red_in   = '0;
		pix_in.green_in = '0;
		pix_in.blue_in  = '0;
		cfg.valid       = 1'b0;
		cfg.index       = '0;
		cfg.data        = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle(IDLE_NONE);
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
				drain_pipeline();
				write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data);
				cfg.valid <= 1'b0;
			end else begin
				typed_pending = DIRECTED_ROWS[i].typed;
				typed_pixel = DIRECTED_ROWS[i].want;
				send_pixel(DIRECTED_ROWS[i].pix);
				typed_pending = 1'b0;
			end
		end

		// Each phase runs under a new set of keep flags, with all kept and all masked first.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 0) begin
				phase_flags = 4'hF;
			end else if (phase == 1) begin
				phase_flags = 4'h0;
			end else begin
				phase_flags = 4'($urandom_range(15));
			end
			apply_keep(phase_flags);
			set_idle(idle_mode_t'(phase % 4));
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				if (phase == 2 && n == PHASE_PIXELS / 2) begin
					drain_pipeline();
				end
				send_pixel(random_pixel());
			end
		end

		drain_pipeline();
		repeat (3 * PIPE_DEPTH) @(negedge clk);

		if (fault_count == 0) begin
			$display("cmyk_channel_mask_filter_core test passed");
		end else begin
			$display("cmyk_channel_mask_filter_core test failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/cmykf_pkg.sv
rtl/cmykf_in_if.sv
rtl/cmykf_out_if.sv
rtl/cmykf_cfg_if.sv
rtl/cmyk_channel_mask_filter_core.sv
tb/sv/tb_cmyk_channel_mask_filter_core.sv
